FILE: hdl/lbp_pkg.sv
package lbp_pkg;

  localparam int unsigned MAX_FIELD_BITS = 32;
  localparam int unsigned BUFFER_BYTES   = 4096;

  localparam int unsigned FBITS_W = 6;
  localparam int unsigned CAP_W   = 13;
  localparam int unsigned ACC_W   = MAX_FIELD_BITS + 7;
  localparam int unsigned NEED_W  = 3;

  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(BUFFER_BYTES);

  typedef struct packed {
    logic [ACC_W-1:0]  acc;
    logic [NEED_W-1:0] nbytes;
    logic              err;
  } job_t;

endpackage

FILE: hdl/lsb_first_bit_packer_core.sv
// An item's first byte reaches out_ through the job queue, the job register
// and the output register. The byte emitter gives one output byte per cycle
// while jobs wait and out_stall is low; input takes one beat per cycle while
// the four-entry job queue has room.
// Reset (synchronous, rst_n low): pending bits, byte count and queue clear,
// capacity_bytes returns to 4096.
module lsb_first_bit_packer_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lbp_pkg::FBITS_W-1:0] in_field_bits,
  input  logic [31:0]                 in_field_value,
  input  logic                        in_flush,
  input  logic                        in_start_new,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte_value,
  output logic                        out_error,
  output logic                        out_last
);
  import lbp_pkg::*;

  localparam logic ADDR_CAP = 1'b0;

  logic [CAP_W-1:0] cap_r;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  job_t             q_wjob;
  job_t             q_rjob;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_CAP) ? {{(32-CAP_W){1'b0}}, cap_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == ADDR_CAP)) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  lbp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cap            (cap_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_field_bits  (in_field_bits),
    .in_field_value (in_field_value),
    .in_flush       (in_flush),
    .in_start_new   (in_start_new),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (q_wjob)
  );

  lbp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wjob),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rjob),
    .empty     (q_empty)
  );

  lbp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_job          (q_rjob),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte_value (out_byte_value),
    .out_error      (out_error),
    .out_last       (out_last)
  );

endmodule

FILE: hdl/lbp_fifo.sv
module lbp_fifo (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  lbp_pkg::job_t push_data,
  output logic         full,
  input  logic         pop,
  output lbp_pkg::job_t pop_data,
  output logic         empty
);
  import lbp_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign full     = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: hdl/lbp_front.sv
module lbp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lbp_pkg::CAP_W-1:0]     cap,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lbp_pkg::FBITS_W-1:0]   in_field_bits,
  input  logic [31:0]                   in_field_value,
  input  logic                          in_flush,
  input  logic                          in_start_new,
  input  logic                          q_full,
  output logic                          q_push,
  output lbp_pkg::job_t                 q_job
);
  import lbp_pkg::*;

  logic [6:0]         pend_bits_r, pend_bits_nxt;
  logic [2:0]         pend_cnt_r, pend_cnt_nxt;
  logic [CAP_W-1:0]   bytes_r, bytes_nxt;

  logic [6:0]         pb_eff;
  logic [2:0]         pc_eff;
  logic [CAP_W-1:0]   be_eff;
  logic [FBITS_W-1:0] nbits;
  logic [32:0]        vmask;
  logic [31:0]        val_m;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   rest;
  logic [FBITS_W-1:0] total;
  logic [NEED_W-1:0]  full_b;
  logic               partial;
  logic [NEED_W-1:0]  need;
  logic [CAP_W-1:0]   cap_eff;
  logic [CAP_W:0]     room;
  logic               err;
  logic [7:0]         pmask;
  logic               accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    pb_eff  = in_start_new ? 7'd0 : pend_bits_r;
    pc_eff  = in_start_new ? 3'd0 : pend_cnt_r;
    be_eff  = in_start_new ? '0   : bytes_r;
    nbits   = (in_field_bits > FBITS_W'(MAX_FIELD_BITS)) ? FBITS_W'(MAX_FIELD_BITS)
                                                         : in_field_bits;
    vmask   = (33'd1 << nbits) - 33'd1;
    val_m   = in_field_value & vmask[31:0];
    acc     = {{(ACC_W-7){1'b0}}, pb_eff} | ({7'd0, val_m} << pc_eff);
    total   = {{(FBITS_W-3){1'b0}}, pc_eff} + nbits;
    full_b  = total[5:3];
    partial = in_flush && (total[2:0] != 3'd0);
    need    = full_b + {2'd0, partial};
    cap_eff = (cap > CAP_RESET) ? CAP_RESET : cap;
    room    = {1'b0, cap_eff} - {1'b0, be_eff};
    err     = room[CAP_W] || ({{(CAP_W-NEED_W){1'b0}}, need} > room[CAP_W-1:0]);
    rest    = acc >> {full_b, 3'b000};
    pmask   = (8'd1 << total[2:0]) - 8'd1;

    if (err) begin
      pend_bits_nxt = pb_eff;
      pend_cnt_nxt  = pc_eff;
      bytes_nxt     = be_eff;
    end else begin
      bytes_nxt = be_eff + {{(CAP_W-NEED_W){1'b0}}, need};
      if (partial) begin
        pend_bits_nxt = 7'd0;
        pend_cnt_nxt  = 3'd0;
      end else begin
        pend_bits_nxt = rest[6:0] & pmask[6:0];
        pend_cnt_nxt  = total[2:0];
      end
    end

    q_job.acc    = err ? '0 : acc;
    q_job.nbytes = err ? NEED_W'(1) : need;
    q_job.err    = err;
    q_push       = accept && (err || (need != '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      bytes_r     <= '0;
    end else if (accept) begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      bytes_r     <= bytes_nxt;
    end
  end

endmodule

FILE: hdl/lbp_back.sv
module lbp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  lbp_pkg::job_t q_job,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte_value,
  output logic          out_error,
  output logic          out_last
);
  import lbp_pkg::*;

  logic              job_valid_r;
  logic [ACC_W-1:0]  job_acc_r;
  logic [NEED_W-1:0] job_left_r;
  logic              job_err_r;

  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_err_r;
  logic              out_last_r;

  logic              adv;
  logic              fin;

  assign adv   = job_valid_r && (!out_valid_r || !out_stall);
  assign fin   = adv && (job_left_r == NEED_W'(1));
  assign q_pop = !q_empty && (!job_valid_r || fin);

  assign out_valid      = out_valid_r;
  assign out_byte_value = out_byte_r;
  assign out_error      = out_err_r;
  assign out_last       = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        job_valid_r <= 1'b1;
      end else if (fin) begin
        job_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_acc_r  <= q_job.acc;
      job_left_r <= q_job.nbytes;
      job_err_r  <= q_job.err;
    end else if (adv) begin
      job_acc_r  <= job_acc_r >> 8;
      job_left_r <= job_left_r - 1'b1;
    end
    if (adv) begin
      out_byte_r <= job_acc_r[7:0];
      out_err_r  <= job_err_r;
      out_last_r <= (job_left_r == NEED_W'(1));
    end
  end

endmodule
